@@ sv/pgat_pkg.sv @@
// ---------------------------------------------------------------------------
// pgat_pkg
// Shared types, widths and helpers of the paged grid address translator.
// ---------------------------------------------------------------------------
package pgat_pkg;

  localparam int COORD_W        = 16;
  localparam int LIN_W          = 48;
  localparam int LVL_W          = 5;
  localparam int PC_W           = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int COORD_BITS_DEF = 16;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_X    = 3'd0,
    REG_GRID_Y    = 3'd1,
    REG_GRID_Z    = 3'd2,
    REG_CELLS_X   = 3'd3,
    REG_CELLS_Y   = 3'd4,
    REG_CELLS_Z   = 3'd5,
    REG_MAX_LEVEL = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [PC_W-1:0]  grid_size_x;
    logic [PC_W-1:0]  grid_size_y;
    logic [PC_W-1:0]  grid_size_z;
    logic [PC_W-1:0]  page_cells_x;
    logic [PC_W-1:0]  page_cells_y;
    logic [PC_W-1:0]  page_cells_z;
    logic [LVL_W-1:0] max_level;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
    logic [LIN_W-1:0]   linear_index;
    logic [COORD_W-1:0] box_pos_x;
    logic [COORD_W-1:0] box_pos_y;
    logic [COORD_W-1:0] box_pos_z;
    logic [COORD_W-1:0] box_size_x;
    logic [COORD_W-1:0] box_size_y;
    logic [COORD_W-1:0] box_size_z;
    logic [LVL_W-1:0]   box_level;
  } in_item_t;

  typedef struct packed {
    logic [LIN_W-1:0] page_number;
    logic [LIN_W-1:0] cell_offset;
    logic [LVL_W-1:0] level_out;
    logic             valid_res;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                 ok;
    logic                 cmd;
    logic [LVL_W-1:0]     level;
    logic [PC_W-1:0]      lx;
    logic [PC_W-1:0]      ly;
    logic [PC_W-1:0]      lz;
    logic [COORD_W-1:0]   sx;
    logic [COORD_W-1:0]   sy;
    logic [COORD_W-1:0]   sz;
    logic [COORD_W-1:0]   px;
    logic [COORD_W-1:0]   py;
    logic [COORD_W-1:0]   pz;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   cy;
    logic [COORD_W-1:0]   cz;
    logic [LIN_W-1:0]     lin;
    logic [2*COORD_W-1:0] plane;
  } desc_t;

  // per-axis cell count at a level, forced to one for pages of at most one cell
  function automatic logic [PC_W-1:0] level_size(input logic [PC_W-1:0] cells,
                                                 input logic [LVL_W-1:0] level);
    logic [PC_W-1:0] res;
    if (cells <= PC_W'(1)) begin
      res = PC_W'(1);
    end else begin
      res = cells >> level;
    end
    return res;
  endfunction

endpackage

@@ sv/pgat_cfg.sv @@
// ---------------------------------------------------------------------------
// pgat_cfg
// Configuration register file, written over its own valid/ready channel.
// ---------------------------------------------------------------------------
module pgat_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pgat_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pgat_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output pgat_pkg::cfg_t                 cfg_o
);
  import pgat_pkg::*;

  cfg_t cfg_q, cfg_d;

  // register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_GRID_X:    cfg_d.grid_size_x  = cfg_data_i;
        REG_GRID_Y:    cfg_d.grid_size_y  = cfg_data_i;
        REG_GRID_Z:    cfg_d.grid_size_z  = cfg_data_i;
        REG_CELLS_X:   cfg_d.page_cells_x = cfg_data_i;
        REG_CELLS_Y:   cfg_d.page_cells_y = cfg_data_i;
        REG_CELLS_Z:   cfg_d.page_cells_z = cfg_data_i;
        REG_MAX_LEVEL: cfg_d.max_level    = cfg_data_i[LVL_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_size_x  <= PC_W'(1);
      cfg_q.grid_size_y  <= PC_W'(1);
      cfg_q.grid_size_z  <= PC_W'(1);
      cfg_q.page_cells_x <= PC_W'(1);
      cfg_q.page_cells_y <= PC_W'(1);
      cfg_q.page_cells_z <= PC_W'(1);
      cfg_q.max_level    <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

endmodule

@@ sv/pgat_front.sv @@
// ---------------------------------------------------------------------------
// pgat_front
// Accepts input beats, masks coordinates, checks the box and level and
// works out level sizes and the box plane area.
// ---------------------------------------------------------------------------
module pgat_front #(
  parameter int COORD_BITS = pgat_pkg::COORD_BITS_DEF
) (
  input  logic               push,
  input  logic               full_i,
  input  pgat_pkg::in_item_t in_i,
  input  pgat_pkg::cfg_t     cfg_i,
  output logic               wr_o,
  output pgat_pkg::desc_t    desc_o
);
  import pgat_pkg::*;

  localparam int CW = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam logic [COORD_W-1:0] CMASK = COORD_W'((17'd1 << CW) - 17'd1);

  desc_t d;

  // classify the item
  always_comb begin
    d.cmd   = in_i.cmd;
    d.level = in_i.box_level;
    d.lin   = in_i.linear_index;
    d.sx    = in_i.box_size_x & CMASK;
    d.sy    = in_i.box_size_y & CMASK;
    d.sz    = in_i.box_size_z & CMASK;
    d.px    = in_i.box_pos_x & CMASK;
    d.py    = in_i.box_pos_y & CMASK;
    d.pz    = in_i.box_pos_z & CMASK;
    d.cx    = in_i.coord_x & CMASK;
    d.cy    = in_i.coord_y & CMASK;
    d.cz    = in_i.coord_z & CMASK;
    d.lx    = level_size(cfg_i.page_cells_x, in_i.box_level);
    d.ly    = level_size(cfg_i.page_cells_y, in_i.box_level);
    d.lz    = level_size(cfg_i.page_cells_z, in_i.box_level);
    d.plane = (2*COORD_W)'(d.sx) * (2*COORD_W)'(d.sy);
    d.ok    = (d.sx != '0) && (d.sy != '0) && (d.sz != '0) &&
              (in_i.box_level <= cfg_i.max_level) &&
              (d.lx != '0) && (d.ly != '0) && (d.lz != '0);
  end

  assign wr_o   = push && !full_i;
  assign desc_o = d;

endmodule

@@ sv/pgat_queue.sv @@
// ---------------------------------------------------------------------------
// pgat_queue
// Two-entry queue between front and back.
// ---------------------------------------------------------------------------
module pgat_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  pgat_pkg::desc_t wdata_i,
  output logic            full_o,
  input  logic            rd_i,
  output pgat_pkg::desc_t rdata_o,
  output logic            empty_o
);
  import pgat_pkg::*;

  desc_t      mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  // pointer and count update
  always_comb begin
    wp_d  = wr_i ? ~wp_q : wp_q;
    rp_d  = rd_i ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(wr_i) - 2'(rd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rp_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count above depth");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> cnt_q != 2'd0) else $error("queue read while empty");
  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i && !rd_i |=> cnt_q == $past(cnt_q) + 2'd1) else $error("queue count lost a beat");
`endif

endmodule

@@ sv/pgat_back.sv @@
// ---------------------------------------------------------------------------
// pgat_back
// Pipelined back end: linear index split, clamp and offset, page/cell split
// and linearization, one divider step per stage.
// ---------------------------------------------------------------------------
module pgat_back #(
  parameter int COORD_BITS = pgat_pkg::COORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pgat_pkg::cfg_t      cfg_i,
  input  pgat_pkg::desc_t     head_i,
  input  logic                head_empty_i,
  output logic                head_rd_o,
  output logic                empty,
  input  logic                pop,
  output pgat_pkg::out_item_t out_o
);
  import pgat_pkg::*;

  localparam int CW     = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int D1     = 2 * CW;
  localparam int R1     = D1 + LIN_W;
  localparam int R2     = 3 * CW;
  localparam int RP     = 2 * PC_W;
  localparam int R3     = PC_W + CW + 1;
  localparam int ST_P2  = LIN_W + 1;
  localparam int END_P2 = LIN_W + 2 * CW;
  localparam int ST_E   = END_P2 + 1;
  localparam int END_L  = ST_E + CW + 1;
  localparam int ST_M1  = END_L + 1;
  localparam int DEPTH  = ST_M1 + 1;

  typedef struct packed {
    logic             ok;
    logic             cmd;
    logic [LVL_W-1:0] level;
    logic [PC_W-1:0]  lx;
    logic [PC_W-1:0]  ly;
    logic [PC_W-1:0]  lz;
    logic [CW-1:0]    sx;
    logic [CW-1:0]    sy;
    logic [CW-1:0]    sz;
    logic [CW-1:0]    px;
    logic [CW-1:0]    py;
    logic [CW-1:0]    pz;
    logic [CW-1:0]    cx;
    logic [CW-1:0]    cy;
    logic [CW-1:0]    cz;
    logic [D1-1:0]    plane;
    logic [R1-1:0]    rq1;
    logic [RP-1:0]    rpx;
    logic [RP-1:0]    rpy;
    logic [RP-1:0]    npxy;
    logic [RP-1:0]    lxy;
    logic [R2-1:0]    rq2;
    logic [R3-1:0]    rqx;
    logic [R3-1:0]    rqy;
    logic [R3-1:0]    rqz;
    logic [LIN_W-1:0] t1;
    logic [LIN_W-1:0] t2;
    logic [LIN_W-1:0] t3;
    logic [LIN_W-1:0] t4;
    logic [LIN_W-1:0] page;
    logic [LIN_W-1:0] offs;
  } stg_t;

  // restoring divider steps, one quotient bit each
  function automatic logic [R1-1:0] div1(input logic [R1-1:0] rq, input logic [D1-1:0] dv);
    logic [R1:0] sh;
    logic [D1:0] top;
    sh  = {rq, 1'b0};
    top = sh[R1 -: D1+1];
    if (top >= {1'b0, dv}) begin
      sh[R1 -: D1+1] = top - {1'b0, dv};
      sh[0]          = 1'b1;
    end
    return sh[R1-1:0];
  endfunction

  function automatic logic [R2-1:0] div2(input logic [R2-1:0] rq, input logic [CW-1:0] dv);
    logic [R2:0] sh;
    logic [CW:0] top;
    sh  = {rq, 1'b0};
    top = sh[R2 -: CW+1];
    if (top >= {1'b0, dv}) begin
      sh[R2 -: CW+1] = top - {1'b0, dv};
      sh[0]          = 1'b1;
    end
    return sh[R2-1:0];
  endfunction

  function automatic logic [RP-1:0] divp(input logic [RP-1:0] rq, input logic [PC_W-1:0] dv);
    logic [RP:0]   sh;
    logic [PC_W:0] top;
    sh  = {rq, 1'b0};
    top = sh[RP -: PC_W+1];
    if (top >= {1'b0, dv}) begin
      sh[RP -: PC_W+1] = top - {1'b0, dv};
      sh[0]            = 1'b1;
    end
    return sh[RP-1:0];
  endfunction

  function automatic logic [R3-1:0] div3(input logic [R3-1:0] rq, input logic [PC_W-1:0] dv);
    logic [R3:0]   sh;
    logic [PC_W:0] top;
    sh  = {rq, 1'b0};
    top = sh[R3 -: PC_W+1];
    if (top >= {1'b0, dv}) begin
      sh[R3 -: PC_W+1] = top - {1'b0, dv};
      sh[0]            = 1'b1;
    end
    return sh[R3-1:0];
  endfunction

  // clamp a coordinate to size - 1
  function automatic logic [CW-1:0] clampc(input logic [LIN_W-1:0] v, input logic [CW-1:0] sz);
    logic [CW-1:0] res;
    if (v >= LIN_W'(sz)) begin
      res = sz - CW'(1);
    end else begin
      res = v[CW-1:0];
    end
    return res;
  endfunction

  stg_t            head_s;
  stg_t            prv   [1:DEPTH];
  stg_t            nxt   [1:DEPTH];
  stg_t            stg_q [1:DEPTH];
  logic            vld_q [1:DEPTH];
  logic            en;
  logic [PC_W-1:0] pdx, pdy;

  // pipeline advances unless the result register is held
  assign en        = !vld_q[DEPTH] || pop;
  assign head_rd_o = en && !head_empty_i;

  // pitch divisors, zero page cells taken as one
  assign pdx = (cfg_i.page_cells_x == '0) ? PC_W'(1) : cfg_i.page_cells_x;
  assign pdy = (cfg_i.page_cells_y == '0) ? PC_W'(1) : cfg_i.page_cells_y;

  // load the queue head into stage form
  always_comb begin
    head_s       = '0;
    head_s.ok    = head_i.ok;
    head_s.cmd   = head_i.cmd;
    head_s.level = head_i.level;
    head_s.lx    = head_i.lx;
    head_s.ly    = head_i.ly;
    head_s.lz    = head_i.lz;
    head_s.sx    = head_i.sx[CW-1:0];
    head_s.sy    = head_i.sy[CW-1:0];
    head_s.sz    = head_i.sz[CW-1:0];
    head_s.px    = head_i.px[CW-1:0];
    head_s.py    = head_i.py[CW-1:0];
    head_s.pz    = head_i.pz[CW-1:0];
    head_s.cx    = head_i.cx[CW-1:0];
    head_s.cy    = head_i.cy[CW-1:0];
    head_s.cz    = head_i.cz[CW-1:0];
    head_s.plane = head_i.plane[D1-1:0];
    head_s.rq1   = {{D1{1'b0}}, head_i.lin};
    head_s.rpx   = {{PC_W{1'b0}}, cfg_i.grid_size_x};
    head_s.rpy   = {{PC_W{1'b0}}, cfg_i.grid_size_y};
  end

  for (genvar i = 1; i <= DEPTH; i++) begin : g_stage
    if (i == 1) begin : g_first
      assign prv[i] = head_s;
    end else begin : g_rest
      assign prv[i] = stg_q[i-1];
    end

    // work of stage i
    always_comb begin
      stg_t             s;
      logic [LIN_W-1:0] vx, vy, vz;
      logic [CW:0]      ax, ay, az;
      s  = prv[i];
      vx = '0;
      vy = '0;
      vz = '0;
      ax = '0;
      ay = '0;
      az = '0;
      // linear index by plane area
      if (i <= LIN_W) begin
        s.rq1 = div1(s.rq1, s.plane);
      end
      // page pitch per axis
      if (i <= PC_W) begin
        s.rpx = divp(s.rpx, pdx);
        s.rpy = divp(s.rpy, pdy);
      end
      if (i == PC_W + 1) begin
        s.npxy = RP'(s.rpx[PC_W-1:0]) * RP'(s.rpy[PC_W-1:0]);
        s.lxy  = RP'(s.lx) * RP'(s.ly);
      end
      // plane remainder by row length
      if (i == ST_P2) begin
        s.rq2 = {{CW{1'b0}}, s.rq1[R1-1:LIN_W]};
      end
      if (i >= ST_P2 && i <= END_P2) begin
        s.rq2 = div2(s.rq2, s.sx);
      end
      // pick coordinates, clamp and add the box origin
      if (i == ST_E) begin
        vx    = s.cmd ? LIN_W'(s.rq2[R2-1:D1]) : LIN_W'(s.cx);
        vy    = s.cmd ? LIN_W'(s.rq2[D1-1:0])  : LIN_W'(s.cy);
        vz    = s.cmd ? s.rq1[LIN_W-1:0]       : LIN_W'(s.cz);
        ax    = {1'b0, s.px} + {1'b0, clampc(vx, s.sx)};
        ay    = {1'b0, s.py} + {1'b0, clampc(vy, s.sy)};
        az    = {1'b0, s.pz} + {1'b0, clampc(vz, s.sz)};
        s.rqx = {{PC_W{1'b0}}, ax};
        s.rqy = {{PC_W{1'b0}}, ay};
        s.rqz = {{PC_W{1'b0}}, az};
      end
      // page and cell split by level size
      if (i > ST_E && i <= END_L) begin
        s.rqx = div3(s.rqx, s.lx);
        s.rqy = div3(s.rqy, s.ly);
        s.rqz = div3(s.rqz, s.lz);
      end
      // linearize: products
      if (i == ST_M1) begin
        s.t1 = LIN_W'(s.rqz[CW:0]) * LIN_W'(s.npxy);
        s.t2 = LIN_W'(s.rqy[CW:0]) * LIN_W'(s.rpx[PC_W-1:0]);
        s.t3 = LIN_W'(s.rqz[R3-1:CW+1]) * LIN_W'(s.lxy);
        s.t4 = LIN_W'(s.rqy[R3-1:CW+1]) * LIN_W'(s.lx);
      end
      // linearize: sums, rejected items give zero
      if (i == DEPTH) begin
        s.page = s.ok ? (s.t1 + s.t2 + LIN_W'(s.rqx[CW:0])) : '0;
        s.offs = s.ok ? (s.t3 + s.t4 + LIN_W'(s.rqx[R3-1:CW+1])) : '0;
      end
      nxt[i] = s;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        if (i == 1) begin
          vld_q[i] <= !head_empty_i;
        end else begin
          vld_q[i] <= vld_q[(i > 1) ? i-1 : 1];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        stg_q[i] <= nxt[i];
      end
    end
  end

  // result beat
  assign empty             = !vld_q[DEPTH];
  assign out_o.page_number = stg_q[DEPTH].page;
  assign out_o.cell_offset = stg_q[DEPTH].offs;
  assign out_o.level_out   = stg_q[DEPTH].level;
  assign out_o.valid_res   = stg_q[DEPTH].ok;

`ifndef SYNTHESIS
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DEPTH] && !stg_q[DEPTH].ok |-> stg_q[DEPTH].page == '0 && stg_q[DEPTH].offs == '0)
    else $error("rejected result carries a nonzero address");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DEPTH] && !pop |=> vld_q[DEPTH] && $stable(stg_q[DEPTH].page))
    else $error("held result changed");
  a_no_read_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DEPTH] && !pop |-> !head_rd_o) else $error("queue read while back stalled");
`endif

endmodule

@@ sv/paged_grid_address_translate.sv @@
// ---------------------------------------------------------------------------
// paged_grid_address_translate
// Turns a voxel position inside a box at a detail level into a page number
// and a cell offset inside that page.
// ---------------------------------------------------------------------------
// throughput: one item per cycle while no held result stalls it, set by the one-step-per-stage divider pipeline
// a held result stalls the pipeline; the two-entry queue then fills and full rises
// reset: asynchronous, clears queue and pipeline valids, registers to their defaults
module paged_grid_address_translate #(
  parameter int COORD_BITS = pgat_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  pgat_pkg::in_item_t             in_i,
  output logic                           empty,
  input  logic                           pop,
  output pgat_pkg::out_item_t            out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pgat_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pgat_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pgat_pkg::*;

  cfg_t  cfg;
  desc_t wdesc, rdesc;
  logic  wr, rd, q_empty;

  pgat_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pgat_front #(.COORD_BITS(COORD_BITS)) u_front (
    .push   (push),
    .full_i (full),
    .in_i   (in_i),
    .cfg_i  (cfg),
    .wr_o   (wr),
    .desc_o (wdesc)
  );

  pgat_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .wdata_i (wdesc),
    .full_o  (full),
    .rd_i    (rd),
    .rdata_o (rdesc),
    .empty_o (q_empty)
  );

  pgat_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_i       (rdesc),
    .head_empty_i (q_empty),
    .head_rd_o    (rd),
    .empty        (empty),
    .pop          (pop),
    .out_o        (out_o)
  );

endmodule
